/* design/clab_pkg.sv */
`timescale 1ns / 1ps

package clab_pkg;

  localparam int REG_BITS         = 13;
  localparam int TEXEL_BITS       = 12;
  localparam int CH_BITS          = 8;
  localparam int NUM_CH           = 3;
  localparam int IDX_BITS         = 24;
  localparam int DIM_BITS_DEFAULT = 12;
  localparam int CFG_IDX_BITS     = 3;
  localparam int IN_DATA_BITS     = 80;
  localparam int OUT_DATA_BITS    = 56;
  localparam int OUT_USER_BITS    = 2;

  localparam logic [CH_BITS-1:0] CH_MAX = '1;

  localparam logic [REG_BITS-1:0] SCREEN_W_RESET = REG_BITS'(640);
  localparam logic [REG_BITS-1:0] SCREEN_H_RESET = REG_BITS'(480);
  localparam logic [REG_BITS-1:0] SPRITE_W_RESET = REG_BITS'(64);
  localparam logic [REG_BITS-1:0] SPRITE_H_RESET = REG_BITS'(64);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SCREEN_W = 3'd0,
    REG_SCREEN_H = 3'd1,
    REG_SPRITE_W = 3'd2,
    REG_SPRITE_H = 3'd3,
    REG_POS_X    = 3'd4,
    REG_POS_Y    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [REG_BITS-1:0]        screen_w;
    logic [REG_BITS-1:0]        screen_h;
    logic [REG_BITS-1:0]        sprite_w;
    logic [REG_BITS-1:0]        sprite_h;
    logic signed [REG_BITS-1:0] pos_x;
    logic signed [REG_BITS-1:0] pos_y;
  } cfg_t;

  // Load enables of the three pipeline stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  typedef logic [NUM_CH-1:0][CH_BITS-1:0] rgb_t;

endpackage

/* design/clab_geom.sv */
`timescale 1ns / 1ps

module clab_geom
  import clab_pkg::*;
#(
  parameter int DIM_BITS = DIM_BITS_DEFAULT
) (
  input  logic                  clk,
  input  stage_en_t             en,
  input  cfg_t                  cfg,
  input  logic [TEXEL_BITS-1:0] texel_x,
  input  logic [TEXEL_BITS-1:0] texel_y,
  input  logic [CH_BITS-1:0]    src_alpha,
  output logic                  keep,
  output logic [IDX_BITS-1:0]   pixel_index
);

  localparam int CW = (DIM_BITS < TEXEL_BITS) ? DIM_BITS : TEXEL_BITS;
  localparam int SW = REG_BITS + 1;

  logic [TEXEL_BITS-1:0]   tx;
  logic [TEXEL_BITS-1:0]   ty;
  logic signed [SW-1:0]    sx_calc;
  logic signed [SW-1:0]    sy_calc;

  logic signed [SW-1:0]    sx1;
  logic signed [SW-1:0]    sy1;
  logic                    in_sprite1;
  logic                    alpha_nz1;

  logic                    vis_calc;
  logic [2*REG_BITS-1:0]   row_calc;
  logic [IDX_BITS-1:0]     row2;
  logic [REG_BITS-1:0]     sx2;
  logic                    keep2;

  logic [IDX_BITS-1:0]     index3;

  assign tx = TEXEL_BITS'(texel_x[CW-1:0]);
  assign ty = TEXEL_BITS'(texel_y[CW-1:0]);

  assign sx_calc = $signed({cfg.pos_x[REG_BITS-1], cfg.pos_x}) + $signed({2'b00, tx});
  assign sy_calc = $signed({cfg.pos_y[REG_BITS-1], cfg.pos_y}) + $signed({2'b00, ty});

  always_ff @(posedge clk) begin
    if (en.s1) begin
      sx1        <= sx_calc;
      sy1        <= sy_calc;
      in_sprite1 <= ({1'b0, tx} < cfg.sprite_w) && ({1'b0, ty} < cfg.sprite_h);
      alpha_nz1  <= (src_alpha != '0);
    end
  end

  // A negative screen coordinate shows as the top bit of the widened sum.
  assign vis_calc = in_sprite1 && !sx1[SW-1] && !sy1[SW-1] &&
                    (sx1[REG_BITS-1:0] < cfg.screen_w) &&
                    (sy1[REG_BITS-1:0] < cfg.screen_h);
  assign row_calc = sy1[REG_BITS-1:0] * cfg.screen_w;

  always_ff @(posedge clk) begin
    if (en.s2) begin
      keep2 <= vis_calc && alpha_nz1;
      row2  <= row_calc[IDX_BITS-1:0];
      sx2   <= sx1[REG_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      index3 <= keep2 ? (row2 + IDX_BITS'(sx2)) : '0;
    end
  end

  assign keep        = keep2;
  assign pixel_index = index3;

endmodule

/* design/clab_mix.sv */
`timescale 1ns / 1ps

module clab_mix
  import clab_pkg::*;
(
  input  logic               clk,
  input  stage_en_t          en,
  input  rgb_t               src_rgb,
  input  rgb_t               dst_rgb,
  input  logic [CH_BITS-1:0] src_alpha,
  input  logic               keep,
  output logic               write_enable,
  output logic               write_alpha,
  output rgb_t               out_rgb,
  output logic [CH_BITS-1:0] out_alpha
);

  localparam int PW = 2 * CH_BITS;

  logic [NUM_CH-1:0][PW-1:0] fore1;
  logic [NUM_CH-1:0][PW-1:0] back1;
  rgb_t                      src1;
  logic                      opaque1;

  logic [NUM_CH-1:0][PW-1:0] num2;
  rgb_t                      src2;
  logic                      opaque2;

  logic [NUM_CH-1:0][PW:0]   quot_sum;
  rgb_t                      blend_calc;

  logic                      we3;
  logic                      wa3;
  rgb_t                      rgb3;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      for (int c = 0; c < NUM_CH; c++) begin
        fore1[c] <= src_alpha * src_rgb[c];
        back1[c] <= (CH_MAX - src_alpha) * dst_rgb[c];
      end
      src1    <= src_rgb;
      opaque1 <= (src_alpha == CH_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      for (int c = 0; c < NUM_CH; c++) begin
        num2[c] <= fore1[c] + back1[c];
      end
      src2    <= src1;
      opaque2 <= opaque1;
    end
  end

  // For a numerator of at most 255 * 255, n / 255 equals (n + (n >> 8) + 1) >> 8 exactly.
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      quot_sum[c]   = {1'b0, num2[c]} + (PW+1)'(num2[c][PW-1:CH_BITS]) + (PW+1)'(1);
      blend_calc[c] = quot_sum[c][PW-1:CH_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      we3  <= keep;
      wa3  <= keep && opaque2;
      rgb3 <= !keep ? '0 : (opaque2 ? src2 : blend_calc);
    end
  end

  assign write_enable = we3;
  assign write_alpha  = wa3;
  assign out_rgb      = rgb3;
  assign out_alpha    = we3 ? CH_MAX : '0;

endmodule

/* design/clipped_alpha_blit.sv */
`timescale 1ns / 1ps
// Channel  Direction  Handshake          Contents
// s_       in         s_tvalid/s_tready  texel coordinates, texel RGBA, screen RGB
// m_       out        m_tvalid/m_tready  write flags, pixel index, RGBA to write
// cfg_     in         cfg_we             register index and value, no read-back
//
// One texel per clock is accepted while s_tready is high; each gives one beat out.
// Three register stages: operand products and screen sums, clip compare with the
// row multiply, then index add and the divide by 255 into the output register.
// An output stall reaches s_tready in the same cycle through the ready chain; empty
// stages still load, so bubbles are filled and no beat is lost.
// Synchronous reset clears the stage valid bits and loads the register defaults.

module clipped_alpha_blit
  import clab_pkg::*;
#(
  parameter int DIM_BITS = DIM_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // texel_x, texel_y, src_red, src_green, src_blue, src_alpha,
  // dst_red, dst_green, dst_blue
  input  logic [IN_DATA_BITS-1:0]  s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // pixel_index, out_red, out_green, out_blue, out_alpha
  output logic [OUT_DATA_BITS-1:0] m_tdata,
  // write_enable, write_alpha
  output logic [OUT_USER_BITS-1:0] m_tuser,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [REG_BITS-1:0]      cfg_wdata
);

  cfg_t       cfg;
  stage_en_t  en;
  logic       v1;
  logic       v2;
  logic       v3;

  logic [TEXEL_BITS-1:0] texel_x;
  logic [TEXEL_BITS-1:0] texel_y;
  rgb_t                  src_rgb;
  rgb_t                  dst_rgb;
  logic [CH_BITS-1:0]    src_alpha;

  logic                  keep;
  logic                  write_enable;
  logic                  write_alpha;
  logic [IDX_BITS-1:0]   pixel_index;
  rgb_t                  out_rgb;
  logic [CH_BITS-1:0]    out_alpha;

  assign texel_x    = s_tdata[11:0];
  assign texel_y    = s_tdata[23:12];
  assign src_rgb[0] = s_tdata[31:24];
  assign src_rgb[1] = s_tdata[39:32];
  assign src_rgb[2] = s_tdata[47:40];
  assign src_alpha  = s_tdata[55:48];
  assign dst_rgb[0] = s_tdata[63:56];
  assign dst_rgb[1] = s_tdata[71:64];
  assign dst_rgb[2] = s_tdata[79:72];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_w <= SCREEN_W_RESET;
      cfg.screen_h <= SCREEN_H_RESET;
      cfg.sprite_w <= SPRITE_W_RESET;
      cfg.sprite_h <= SPRITE_H_RESET;
      cfg.pos_x    <= '0;
      cfg.pos_y    <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SCREEN_W: cfg.screen_w <= cfg_wdata;
        REG_SCREEN_H: cfg.screen_h <= cfg_wdata;
        REG_SPRITE_W: cfg.sprite_w <= cfg_wdata;
        REG_SPRITE_H: cfg.sprite_h <= cfg_wdata;
        REG_POS_X:    cfg.pos_x    <= cfg_wdata;
        REG_POS_Y:    cfg.pos_y    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or its contents move on in the same cycle.
  assign en.s3    = !v3 || m_tready;
  assign en.s2    = !v2 || en.s3;
  assign en.s1    = !v1 || en.s2;
  assign s_tready = en.s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en.s1) v1 <= s_tvalid;
      if (en.s2) v2 <= v1;
      if (en.s3) v3 <= v2;
    end
  end

  clab_geom #(
    .DIM_BITS(DIM_BITS)
  ) u_geom (
    .clk        (clk),
    .en         (en),
    .cfg        (cfg),
    .texel_x    (texel_x),
    .texel_y    (texel_y),
    .src_alpha  (src_alpha),
    .keep       (keep),
    .pixel_index(pixel_index)
  );

  clab_mix u_mix (
    .clk         (clk),
    .en          (en),
    .src_rgb     (src_rgb),
    .dst_rgb     (dst_rgb),
    .src_alpha   (src_alpha),
    .keep        (keep),
    .write_enable(write_enable),
    .write_alpha (write_alpha),
    .out_rgb     (out_rgb),
    .out_alpha   (out_alpha)
  );

  assign m_tvalid = v3;
  assign m_tdata  = {out_alpha, out_rgb[2], out_rgb[1], out_rgb[0], pixel_index};
  assign m_tuser  = {write_alpha, write_enable};

endmodule

/* design/clab_checker.sv */
`timescale 1ns / 1ps

module clab_checker
  import clab_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     s_tvalid,
  input logic                     s_tready,
  input logic                     m_tvalid,
  input logic                     m_tready,
  input logic [OUT_DATA_BITS-1:0] m_tdata,
  input logic [OUT_USER_BITS-1:0] m_tuser
);

  // A held beat keeps its payload until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output beat changed while stalled");

  // An opaque copy is always a write.
  a_alpha_needs_write: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tuser[0])
    else $error("alpha write flagged without a pixel write");

  // A clipped or transparent texel carries an all-zero payload.
  a_zero_when_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("payload not cleared for a texel that writes nothing");

  // Every written pixel carries a full alpha byte.
  a_alpha_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[55:48] == CH_MAX)
    else $error("written pixel lacks a full alpha byte");

  // With nothing in flight the input side must be open.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid && $past(!m_tvalid) && $past(!m_tvalid, 2) && $past(!s_tvalid)
      && $past(!s_tvalid, 2) && $past(!s_tvalid, 3) && $past(!rst, 3) |-> s_tready)
    else $error("input stalled with the pipeline empty");

endmodule

bind clipped_alpha_blit clab_checker u_clab_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);
